@@ rtl/core/cdq_pkg.sv @@
// shared types and constants for the circular double-ended queue
// action and status codes, widths, controller/datapath command and status structs
// no dependencies
package cdq_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int WORD_W = 32;
	localparam int ACT_W  = 4;
	localparam int ST_W   = 2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 4'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 4'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 4'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 4'd3;
	localparam logic [ACT_W-1:0] ACT_READ_FRONT = 4'd4;
	localparam logic [ACT_W-1:0] ACT_READ_BACK  = 4'd5;
	localparam logic [ACT_W-1:0] ACT_READ_INDEX = 4'd6;
	localparam logic [ACT_W-1:0] ACT_RESIZE     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd8;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_INDEX = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic exec;
		logic fill;
		logic load_result;
	} cdq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic grow;
		logic fill_last;
	} cdq_sts_t;

endpackage

@@ rtl/core/cdq_ctrl.sv @@
// controller state machine for the circular double-ended queue
// sequences accept, execute, fill and respond; drives the result valid flag
// depends on cdq_pkg
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              result_valid,
	input  logic              result_ready,
	input  cdq_pkg::cdq_sts_t sts,
	output cdq_pkg::cdq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       res_valid_q;
	logic       slot_free;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = res_valid_q;
	assign slot_free    = !res_valid_q || result_ready;

	// next state and commands
	always_comb begin
		state_d         = state_q;
		cmd.load_item   = 1'b0;
		cmd.exec        = 1'b0;
		cmd.fill        = 1'b0;
		cmd.load_result = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.grow ? S_FILL : S_RESP;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (slot_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/cdq_dp.sv @@
// datapath for the circular double-ended queue
// item register, head and occupancy, circular store, fill counter, result register
// depends on cdq_pkg
module cdq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdq_pkg::cdq_cmd_t                   cmd,
	output cdq_pkg::cdq_sts_t                   sts,
	input  logic [cdq_pkg::ACT_W-1:0]           action,
	input  logic signed [cdq_pkg::WORD_W-1:0]   value,
	input  logic [cdq_pkg::ADDR_W-1:0]          index,
	input  logic [cdq_pkg::CNT_W-1:0]           new_count,
	output logic signed [cdq_pkg::WORD_W-1:0]   read_value,
	output logic [cdq_pkg::CNT_W-1:0]           count,
	output logic                                is_empty,
	output logic [cdq_pkg::ST_W-1:0]            status
);

	localparam int AW = cdq_pkg::ADDR_W;
	localparam int CW = cdq_pkg::CNT_W;
	localparam int WW = cdq_pkg::WORD_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(cdq_pkg::DEPTH);

	// item register
	logic [cdq_pkg::ACT_W-1:0] act_q;
	logic [WW-1:0]             val_q;
	logic [AW-1:0]             idx_q;
	logic [CW-1:0]             ncnt_q;

	// queue state
	logic [AW-1:0] head_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] fill_q;

	// per-item outcome
	logic [cdq_pkg::ST_W-1:0] st_q;
	logic                     rd_ok_q;
	logic [WW-1:0]            rdata_q;

	// result register
	logic [WW-1:0]            res_val_q;
	logic [CW-1:0]            res_cnt_q;
	logic [cdq_pkg::ST_W-1:0] res_st_q;

	logic [WW-1:0] mem [cdq_pkg::DEPTH];

	logic [cdq_pkg::ST_W-1:0] st_d;
	logic                     rd_ok_d;
	logic [AW-1:0]            head_d;
	logic [CW-1:0]            occ_d;
	logic                     ex_wr;
	logic [AW-1:0]            ex_wr_addr;
	logic [AW-1:0]            rd_addr;
	logic                     grow_d;
	logic                     q_full;
	logic                     q_empty;
	logic [AW-1:0]            back_slot;
	logic                     mem_wr;
	logic [AW-1:0]            mem_wr_addr;

	assign q_full    = (occ_q == FULL_CNT);
	assign q_empty   = (occ_q == '0);
	assign back_slot = head_q + occ_q[AW-1:0];

	// decode the held item against the current queue state
	always_comb begin
		st_d       = cdq_pkg::ST_OK;
		rd_ok_d    = 1'b0;
		head_d     = head_q;
		occ_d      = occ_q;
		ex_wr      = 1'b0;
		ex_wr_addr = back_slot;
		rd_addr    = head_q;
		grow_d     = 1'b0;
		case (act_q)
			cdq_pkg::ACT_PUSH_FRONT: begin
				if (q_full) begin
					st_d = cdq_pkg::ST_FULL;
				end else begin
					head_d     = head_q - AW'(1);
					ex_wr      = 1'b1;
					ex_wr_addr = head_q - AW'(1);
					occ_d      = occ_q + CW'(1);
				end
			end
			cdq_pkg::ACT_PUSH_BACK: begin
				if (q_full) begin
					st_d = cdq_pkg::ST_FULL;
				end else begin
					ex_wr = 1'b1;
					occ_d = occ_q + CW'(1);
				end
			end
			cdq_pkg::ACT_POP_FRONT: begin
				if (q_empty) begin
					st_d = cdq_pkg::ST_EMPTY;
				end else begin
					head_d = head_q + AW'(1);
					occ_d  = occ_q - CW'(1);
				end
			end
			cdq_pkg::ACT_POP_BACK: begin
				if (q_empty) begin
					st_d = cdq_pkg::ST_EMPTY;
				end else begin
					occ_d = occ_q - CW'(1);
				end
			end
			cdq_pkg::ACT_READ_FRONT: begin
				if (q_empty) begin
					st_d = cdq_pkg::ST_EMPTY;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			cdq_pkg::ACT_READ_BACK: begin
				rd_addr = back_slot - AW'(1);
				if (q_empty) begin
					st_d = cdq_pkg::ST_EMPTY;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			cdq_pkg::ACT_READ_INDEX: begin
				rd_addr = head_q + idx_q;
				if ({1'b0, idx_q} >= occ_q) begin
					st_d = cdq_pkg::ST_INDEX;
				end else begin
					rd_ok_d = 1'b1;
				end
			end
			cdq_pkg::ACT_RESIZE: begin
				if (ncnt_q > FULL_CNT) begin
					st_d = cdq_pkg::ST_FULL;
				end else begin
					occ_d  = ncnt_q;
					grow_d = (ncnt_q > occ_q);
				end
			end
			cdq_pkg::ACT_CLEAR: begin
				head_d = '0;
				occ_d  = '0;
			end
			default: begin
			end
		endcase
	end

	assign sts.grow      = grow_d;
	assign sts.fill_last = ((fill_q + CW'(1)) == ncnt_q);

	// single write port shared by pushes and the resize fill
	assign mem_wr      = (cmd.exec && ex_wr) || cmd.fill;
	assign mem_wr_addr = cmd.fill ? (head_q + fill_q[AW-1:0]) : ex_wr_addr;

	// circular store
	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[mem_wr_addr] <= val_q;
		end
		if (cmd.exec) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// item, outcome and result payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q  <= action;
			val_q  <= value;
			idx_q  <= index;
			ncnt_q <= new_count;
		end
		if (cmd.exec) begin
			st_q    <= st_d;
			rd_ok_q <= rd_ok_d;
		end
		if (cmd.exec) begin
			fill_q <= occ_q;
		end else if (cmd.fill) begin
			fill_q <= fill_q + CW'(1);
		end
		if (cmd.load_result) begin
			res_val_q <= rd_ok_q ? rdata_q : '0;
			res_cnt_q <= occ_q;
			res_st_q  <= st_q;
		end
	end

	// head and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			occ_q  <= occ_d;
		end
	end

	assign read_value = res_val_q;
	assign count      = res_cnt_q;
	assign is_empty   = (res_cnt_q == '0);
	assign status     = res_st_q;

endmodule

@@ rtl/core/circular_double_ended_queue_core.sv @@
// Circular double-ended queue of signed 32-bit words, 1024 entries.
// Item channel (item_valid/item_ready) carries action, value, index and
// new_count; one beat per operation: push or pop at either end, read
// front, back or a position, resize with a fill word, or clear.
// Result channel (result_valid/result_ready) returns exactly one beat per
// item: read_value (zero unless a read succeeds), count after the action,
// is_empty and a status code (ok, empty, full, bad index). Failed actions
// leave the queue unchanged.
// Sequence: an item is taken in the idle state, executed in the execute
// state, and its result is registered in the respond state; no new item
// is taken until that result is loaded. A resize that grows the queue from
// c to n elements writes the value word to the n - c new slots in the fill
// state, one fill write per cycle through the single store write port.
// A stalled result holds in the output register; the item being worked on
// waits for the result slot and no new item is taken meanwhile.
// Reset clears head, occupancy and all handshake state; the store needs no
// clearing since entries are only read after they are written.
// Depends on cdq_pkg, cdq_ctrl and cdq_dp.
module circular_double_ended_queue_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [cdq_pkg::ACT_W-1:0]           action,
	input  logic signed [cdq_pkg::WORD_W-1:0]   value,
	input  logic [cdq_pkg::ADDR_W-1:0]          index,
	input  logic [cdq_pkg::CNT_W-1:0]           new_count,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [cdq_pkg::WORD_W-1:0]   read_value,
	output logic [cdq_pkg::CNT_W-1:0]           count,
	output logic                                is_empty,
	output logic [cdq_pkg::ST_W-1:0]            status
);

	cdq_pkg::cdq_cmd_t cmd;
	cdq_pkg::cdq_sts_t sts;

	// controller
	cdq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath
	cdq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.value      (value),
		.index      (index),
		.new_count  (new_count),
		.read_value (read_value),
		.count      (count),
		.is_empty   (is_empty),
		.status     (status)
	);

	// no fill write while a new beat can be taken
	a_no_fill_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !cmd.fill)
		else $error("fill active while accepting items");

	// loading a result always raises result valid
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> result_valid)
		else $error("result loaded but not presented");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !cmd.load_result)
		else $error("pending result overwritten");

	// reported count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (count <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH)))
		else $error("count beyond depth");

endmodule
